### rtl/pbsc_pkg.sv
// Shared types and constants of the price bar setup counter.
// Used by pbsc_core and price_bar_setup_counter; depends on nothing.
package pbsc_pkg;

   localparam int PRICE_BITS    = 32;
   localparam int HISTORY_DEPTH = 5;
   localparam int SEEN_BITS     = $clog2(HISTORY_DEPTH + 1);
   localparam int COUNT_BITS    = 4;

   localparam logic [SEEN_BITS-1:0]  BARS_NEEDED   = SEEN_BITS'(HISTORY_DEPTH);
   localparam logic [COUNT_BITS-1:0] COUNT_FIRST   = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_PERFECT = COUNT_BITS'(8);
   localparam logic [COUNT_BITS-1:0] COUNT_LAST    = COUNT_BITS'(9);

   // Setup direction codes, two's complement
   localparam logic [1:0] DIR_NONE = 2'b00;
   localparam logic [1:0] DIR_BUY  = 2'b01;
   localparam logic [1:0] DIR_SELL = 2'b11;

   typedef logic [PRICE_BITS-1:0] price_type;

   typedef struct packed {
      price_type close_price;
      price_type low_price;
      price_type high_price;
   } bar_type;

   typedef struct packed {
      logic [PRICE_BITS-1:0] level_price;
      logic                  perfected;
      logic [COUNT_BITS-1:0] setup_count;
      logic signed [1:0]     direction;
      logic                  ready_res;
   } result_type;

endpackage

### rtl/pbsc_core.sv
// Setup state and combinational bar evaluation of the price bar setup counter.
// Holds the price histories and the previous result; depends on pbsc_pkg.
module pbsc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  pbsc_pkg::bar_type    bar,
   output pbsc_pkg::result_type result
);
   import pbsc_pkg::*;

   price_type                close_hist_ff [HISTORY_DEPTH];
   price_type                high_hist_ff  [2];
   price_type                low_hist_ff   [2];
   logic [SEEN_BITS-1:0]     bars_seen_ff;
   logic [1:0]               last_dir_ff, last_dir_in;
   logic [COUNT_BITS-1:0]    last_count_ff, last_count_in;
   price_type                extreme_ff, extreme_in;
   price_type                last_level_ff, last_level_in;

   logic                     warm;
   logic                     buy_flip, sell_flip, buy_cont, sell_cont;
   logic [COUNT_BITS-1:0]    cont_count;
   logic [1:0]               dir;
   logic [COUNT_BITS-1:0]    cnt;
   logic                     perf;
   price_type                level;
   price_type                c1, c4, c5;

   assign c1 = close_hist_ff[0];
   assign c4 = close_hist_ff[3];
   assign c5 = close_hist_ff[4];

   always_comb begin
      warm       = (bars_seen_ff >= BARS_NEEDED);
      buy_flip   = (bar.close_price <= c4) && (c1 >= c5);
      sell_flip  = !buy_flip && (bar.close_price >= c4) && (c1 <= c5);
      buy_cont   = !buy_flip && !sell_flip && (bar.close_price < c4)
                   && (last_dir_ff == DIR_BUY);
      sell_cont  = !buy_flip && !sell_flip && !buy_cont && (bar.close_price > c4)
                   && (last_dir_ff == DIR_SELL);
      // restart at one after a nine
      cont_count = (last_count_ff == COUNT_LAST) ? COUNT_FIRST
                                                 : last_count_ff + COUNT_FIRST;

      dir        = DIR_NONE;
      cnt        = '0;
      extreme_in = extreme_ff;
      if (buy_flip) begin
         dir        = DIR_BUY;
         cnt        = COUNT_FIRST;
         extreme_in = bar.high_price;
      end else if (sell_flip) begin
         dir        = DIR_SELL;
         cnt        = COUNT_FIRST;
         extreme_in = bar.low_price;
      end else if (buy_cont) begin
         dir = DIR_BUY;
         cnt = cont_count;
         if (last_count_ff != COUNT_LAST && bar.high_price > extreme_ff) begin
            extreme_in = bar.high_price;
         end
      end else if (sell_cont) begin
         dir = DIR_SELL;
         cnt = cont_count;
         if (last_count_ff != COUNT_LAST && bar.low_price < extreme_ff) begin
            extreme_in = bar.low_price;
         end
      end

      perf = 1'b0;
      if (cnt >= COUNT_PERFECT) begin
         if (dir == DIR_BUY) begin
            perf = bar.low_price < low_hist_ff[1];
         end else if (dir == DIR_SELL) begin
            perf = bar.high_price > high_hist_ff[1];
         end
      end

      level = (cnt == COUNT_LAST) ? extreme_in : last_level_ff;
      // drop the level once the close crosses it
      if ((last_dir_ff == DIR_BUY && bar.close_price > level) ||
          (last_dir_ff == DIR_SELL && bar.close_price < level)) begin
         level = '0;
      end

      last_dir_in   = dir;
      last_count_in = cnt;
      last_level_in = level;

      result = '0;
      if (warm) begin
         result.ready_res   = 1'b1;
         result.direction   = dir;
         result.setup_count = cnt;
         result.perfected   = perf;
         result.level_price = level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            close_hist_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            high_hist_ff[i] <= '0;
            low_hist_ff[i]  <= '0;
         end
         bars_seen_ff  <= '0;
         last_dir_ff   <= DIR_NONE;
         last_count_ff <= '0;
         extreme_ff    <= '0;
         last_level_ff <= '0;
      end else if (step) begin
         for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            close_hist_ff[i] <= close_hist_ff[i-1];
         end
         close_hist_ff[0] <= bar.close_price;
         high_hist_ff[1]  <= high_hist_ff[0];
         high_hist_ff[0]  <= bar.high_price;
         low_hist_ff[1]   <= low_hist_ff[0];
         low_hist_ff[0]   <= bar.low_price;
         if (warm) begin
            last_dir_ff   <= last_dir_in;
            last_count_ff <= last_count_in;
            extreme_ff    <= extreme_in;
            last_level_ff <= last_level_in;
         end else begin
            bars_seen_ff <= bars_seen_ff + SEEN_BITS'(1);
         end
      end
   end

endmodule

### rtl/price_bar_setup_counter.sv
// Top level of the price bar setup counter: stream ports, request register
// and result register around pbsc_core; depends on pbsc_pkg and pbsc_core.
//
// One closed price bar per request gives one result. A bar is taken every
// cycle when the result side keeps up; a result is offered once its request
// has passed the request register and then the result register, which it
// enters when that register is free. The rate is set by the update of the
// setup state (count, direction, extreme and level), which each bar reads
// from the bar before it. The first five bars only fill the price histories
// and return a result with ready_res low and all other fields zero.
module price_bar_setup_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // high_price[31:0], low_price[63:32], close_price[95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // direction[1:0], setup_count[5:2], perfected[6],
                                   // level_price[38:7], zero[39]
   output logic [0:0]  rsp_tuser   // ready_res[0]
);
   import pbsc_pkg::*;

   logic       req_valid_ff;
   bar_type    req_bar_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       advance;

   // move the held request into the result register when it is free
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   pbsc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .bar    (req_bar_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_bar_ff.high_price  <= req_tdata[31:0];
         req_bar_ff.low_price   <= req_tdata[63:32];
         req_bar_ff.close_price <= req_tdata[95:64];
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.level_price, rsp_ff.perfected,
                        rsp_ff.setup_count, rsp_ff.direction};
   assign rsp_tuser  = rsp_ff.ready_res;

endmodule
